@@ sv/mmap_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, kind codes and address map helpers for the memory map
// no dependencies

package mmap_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int OAM_LENGTH = 160;
    localparam int OAM_BASE   = 65024;
    localparam int POS_W      = $clog2(OAM_LENGTH + 1);
    localparam int STEP_W     = 6;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [ADDR_W-1:0] HOLE_LO     = 16'hFEA0;
    localparam logic [ADDR_W-1:0] HOLE_HI     = 16'hFEFF;
    localparam logic [ADDR_W-1:0] ECHO_LO     = 16'hE000;
    localparam logic [ADDR_W-1:0] ECHO_HI     = 16'hFDFF;
    localparam logic [ADDR_W-1:0] ECHO_OFFSET = 16'h2000;
    localparam logic [ADDR_W-1:0] ROM_TOP     = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_SC      = 16'hFF02;
    localparam logic [ADDR_W-1:0] REG_DMA     = 16'hFF46;
    localparam logic [ADDR_W-1:0] REG_BOOT    = 16'hFF50;
    localparam logic [DATA_W-1:0] SC_UNUSED   = 8'h7E;

    function automatic logic is_hole(input logic [ADDR_W-1:0] a);
        return (a >= HOLE_LO) && (a <= HOLE_HI);
    endfunction

    function automatic logic [ADDR_W-1:0] map_echo(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] m;
        m = a;
        if ((a >= ECHO_LO) && (a <= ECHO_HI))
        begin
            m = a - ECHO_OFFSET;
        end
        return m;
    endfunction

endpackage

@@ sv/mmap_ram.sv @@
`timescale 1ns / 1ps
// generic single-port synchronous ram, one access per cycle, registered read
// no dependencies

module mmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/memory_map_with_oam_dma.sv @@
`timescale 1ns / 1ps
// memory map top level: 64k byte store, bus read/write map and oam dma engine
// depends on mmap_pkg and mmap_ram

// After reset the block sweeps the whole 64k store to zero, one byte a cycle,
// so busy stays high through the sweep, before the first command is taken.
// A write ends in idle, a read adds a wait state for the ram read, a tick with
// dma active and at least one whole step alternates a read and a write state per
// copied byte (a read and a write of the single ram port per byte), plus a step
// state on finding the transfer complete; other commands end in idle. The result
// beat shows on done for one cycle after the command ends and cannot be stalled.

module memory_map_with_oam_dma
    import mmap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  logic [7:0]        tick_cycles,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              dma_busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_DMA_STEP,
        ST_DMA_WR
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                active_reg, active_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0]   page_reg, page_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                rd_zero_reg, rd_zero_next;
    logic                rd_sc_reg, rd_sc_next;
    logic                done_reg, done_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic                busy_out_reg, busy_out_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;
    logic [DATA_W-1:0]   fixed_rdata;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   dma_src;
    logic [ADDR_W-1:0]   dma_dst;

    mmap_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign fixed_rdata = rd_zero_reg ? '0 : (ram_rdata | (rd_sc_reg ? SC_UNUSED : '0));
    assign wr_addr     = map_echo(address);
    assign dma_src     = {page_reg, pos_reg[7:0]};
    assign dma_dst     = ADDR_W'(OAM_BASE) | {8'h00, pos_reg[7:0]};

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        active_next   = active_reg;
        pos_next      = pos_reg;
        page_next     = page_reg;
        steps_next    = steps_reg;
        rd_zero_next  = rd_zero_reg;
        rd_sc_next    = rd_sc_reg;
        done_next     = 1'b0;
        rdata_next    = rdata_reg;
        busy_out_next = busy_out_reg;
        ram_we        = 1'b0;
        ram_addr      = address;
        ram_wdata     = write_data;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind)
                        KIND_READ:
                        begin
                            ram_addr     = map_echo(address);
                            rd_zero_next = is_hole(address);
                            rd_sc_next   = (address == REG_SC);
                            state_next   = ST_READ_WAIT;
                        end
                        KIND_WRITE:
                        begin
                            if (address == REG_DMA)
                            begin
                                ram_we      = 1'b1;
                                ram_addr    = address;
                                page_next   = write_data;
                                pos_next    = '0;
                                active_next = 1'b1;
                            end
                            else if ((address != REG_BOOT) && !is_hole(address)
                                     && (wr_addr >= ROM_TOP))
                            begin
                                ram_we   = 1'b1;
                                ram_addr = wr_addr;
                            end
                            done_next     = 1'b1;
                            rdata_next    = '0;
                            busy_out_next = (address == REG_DMA) ? 1'b1 : active_reg;
                        end
                        KIND_TICK:
                        begin
                            steps_next = tick_cycles[7:2];
                            if (active_reg && (tick_cycles[7:2] != '0))
                            begin
                                state_next = ST_DMA_STEP;
                            end
                            else
                            begin
                                done_next     = 1'b1;
                                rdata_next    = '0;
                                busy_out_next = active_reg;
                            end
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            rdata_next    = '0;
                            busy_out_next = active_reg;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                done_next     = 1'b1;
                rdata_next    = fixed_rdata;
                busy_out_next = active_reg;
                state_next    = ST_IDLE;
            end
            ST_DMA_STEP:
            begin
                if (pos_reg >= POS_W'(OAM_LENGTH))
                begin
                    active_next   = 1'b0;
                    pos_next      = '0;
                    done_next     = 1'b1;
                    rdata_next    = '0;
                    busy_out_next = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ram_addr     = map_echo(dma_src);
                    rd_zero_next = is_hole(dma_src);
                    rd_sc_next   = (dma_src == REG_SC);
                    state_next   = ST_DMA_WR;
                end
            end
            ST_DMA_WR:
            begin
                ram_we     = 1'b1;
                ram_addr   = dma_dst;
                ram_wdata  = fixed_rdata;
                pos_next   = pos_reg + 1'b1;
                steps_next = steps_reg - 1'b1;
                if (steps_reg == STEP_W'(1))
                begin
                    done_next     = 1'b1;
                    rdata_next    = '0;
                    busy_out_next = active_reg;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DMA_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            active_reg   <= 1'b0;
            pos_reg      <= '0;
            page_reg     <= '0;
            steps_reg    <= '0;
            rd_zero_reg  <= 1'b0;
            rd_sc_reg    <= 1'b0;
            done_reg     <= 1'b0;
            rdata_reg    <= '0;
            busy_out_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            active_reg   <= active_next;
            pos_reg      <= pos_next;
            page_reg     <= page_next;
            steps_reg    <= steps_next;
            rd_zero_reg  <= rd_zero_next;
            rd_sc_reg    <= rd_sc_next;
            done_reg     <= done_next;
            rdata_reg    <= rdata_next;
            busy_out_reg <= busy_out_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign dma_busy  = busy_out_reg;

endmodule
